// ===== rtl/core/mexp_pkg.sv =====
// shared types and constants of the modular exponentiation unit
`default_nettype none
package mexp_pkg;

    localparam int DEFAULT_OPERAND_BITS = 32;
    localparam int FIELD_BITS           = 32;
    localparam int APB_ADDR_W           = 4;
    localparam int APB_DATA_W           = 32;
    localparam int MSG_BITS             = 8;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [FIELD_BITS-1:0] base_value;
    } mexp_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] power_result;
        logic                  bad_modulus;
    } mexp_out_t;

    typedef struct packed {
        logic [APB_DATA_W-1:0] modulus;
        logic [APB_DATA_W-1:0] public_exponent;
        logic [APB_DATA_W-1:0] private_exponent;
    } mexp_cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mexp_rem_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/mexp_regs.sv =====
// apb register file holding modulus and both exponents
`default_nettype none
module mexp_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mexp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mexp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mexp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output mexp_pkg::mexp_cfg_t                  cfg
);

    logic [mexp_pkg::APB_DATA_W-1:0] modulus_reg;
    logic [mexp_pkg::APB_DATA_W-1:0] public_exp_reg;
    logic [mexp_pkg::APB_DATA_W-1:0] private_exp_reg;
    logic [1:0]                      reg_index;
    logic                            wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg     <= '0;
            public_exp_reg  <= '0;
            private_exp_reg <= '0;
        end else if (wr_en) begin
            case (reg_index)
                mexp_pkg::REG_MODULUS:     modulus_reg     <= pwdata;
                mexp_pkg::REG_PUBLIC_EXP:  public_exp_reg  <= pwdata;
                mexp_pkg::REG_PRIVATE_EXP: private_exp_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            mexp_pkg::REG_MODULUS:     prdata = modulus_reg;
            mexp_pkg::REG_PUBLIC_EXP:  prdata = public_exp_reg;
            mexp_pkg::REG_PRIVATE_EXP: prdata = private_exp_reg;
            default:                   prdata = '0;
        endcase
    end

    assign cfg.modulus          = modulus_reg;
    assign cfg.public_exponent  = public_exp_reg;
    assign cfg.private_exponent = private_exp_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mexp_rem.sv =====
// bit-serial restoring remainder unit: dividend mod divisor, one bit a cycle
`default_nettype none
module mexp_rem #(
    parameter int OPERAND_BITS = mexp_pkg::DEFAULT_OPERAND_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [2*OPERAND_BITS-1:0] dividend,
    input  wire logic [OPERAND_BITS-1:0]   divisor,
    output logic      [OPERAND_BITS-1:0]   remainder,
    output mexp_pkg::mexp_rem_status_t     status
);

    localparam int W     = OPERAND_BITS;
    localparam int CNT_W = $clog2(2 * W + 1);

    logic [2*W-1:0]   div_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       trial;
    logic [W:0]       divisor_ext;

    assign trial       = {rem_reg, div_reg[2*W-1]};
    assign divisor_ext = {1'b0, divisor};

    always_comb begin
        if (trial >= divisor_ext) begin
            rem_next = W'(trial - divisor_ext);
        end else begin
            rem_next = trial[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(2 * W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            div_reg <= {div_reg[2*W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

// ===== rtl/core/modular_exponentiation_unit.sv =====
// modular exponentiation unit: square-and-multiply over a shared remainder unit
// One item at a time: base^exponent mod modulus, exponent and modulus from the
// apb registers (modulus at 0x0, public exponent at 0x4, private exponent at 0x8).
// With W = OPERAND_BITS, every modular product goes through a single registered
// W x W multiplier and then the bit-serial remainder unit, which works through
// the 2W-bit product bit by bit. A zero modulus or a zero exponent skips the
// reductions and goes from the transfer straight to the finish state. s_ready
// rises with m_valid; a finished result sits in the output register while the
// next item is taken in, and an item that finishes while that result is still
// unaccepted waits for it.
`default_nettype none
module modular_exponentiation_unit #(
    parameter int OPERAND_BITS = mexp_pkg::DEFAULT_OPERAND_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire mexp_pkg::mexp_in_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output mexp_pkg::mexp_out_t                  m_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mexp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mexp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mexp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    localparam int W = OPERAND_BITS;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_BASE_RED = 3'd1;
    localparam logic [2:0] ST_CHECK    = 3'd2;
    localparam logic [2:0] ST_MUL_ACC  = 3'd3;
    localparam logic [2:0] ST_RED_ACC  = 3'd4;
    localparam logic [2:0] ST_MUL_SQ   = 3'd5;
    localparam logic [2:0] ST_RED_SQ   = 3'd6;
    localparam logic [2:0] ST_FINISH   = 3'd7;

    mexp_pkg::mexp_cfg_t        cfg;
    mexp_pkg::mexp_rem_status_t rem_status;
    mexp_pkg::mexp_out_t        out_reg;

    logic [2:0]     state_reg;
    logic [2:0]     state_next;
    logic [W-1:0]   expo_reg;
    logic [W-1:0]   acc_reg;
    logic [W-1:0]   sq_reg;
    logic [W-1:0]   res_reg;
    logic           bad_reg;
    logic           kind_reg;
    logic [2*W-1:0] prod_reg;
    logic           start_reg;
    logic           out_valid_reg;
    logic [W-1:0]   modulus;
    logic [W-1:0]   sel_expo;
    logic [W-1:0]   sel_base;
    logic [W-1:0]   mul_a;
    logic [2*W-1:0] prod_next;
    logic [W-1:0]   rem_value;
    logic           take_in;
    logic           load_out;

    mexp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mexp_rem #(
        .OPERAND_BITS (W)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .dividend  (prod_reg),
        .divisor   (modulus),
        .remainder (rem_value),
        .status    (rem_status)
    );

    assign modulus  = cfg.modulus[W-1:0];
    assign sel_expo = (s_data.kind == mexp_pkg::KIND_DECRYPT) ?
                      cfg.private_exponent[W-1:0] : cfg.public_exponent[W-1:0];
    assign sel_base = (s_data.kind == mexp_pkg::KIND_DECRYPT) ?
                      s_data.base_value[W-1:0] :
                      W'(s_data.base_value[mexp_pkg::MSG_BITS-1:0]);

    assign mul_a     = (state_reg == ST_MUL_ACC) ? acc_reg : sq_reg;
    assign prod_next = {{W{1'b0}}, mul_a} * {{W{1'b0}}, sq_reg};

    assign s_ready  = (state_reg == ST_IDLE);
    assign take_in  = s_valid & s_ready;
    assign load_out = (state_reg == ST_FINISH) & (~out_valid_reg | m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_in) begin
                    if (modulus == '0 || sel_expo == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_BASE_RED;
                    end
                end
            end
            ST_BASE_RED: begin
                if (rem_status.done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = expo_reg[0] ? ST_MUL_ACC : ST_MUL_SQ;
            end
            ST_MUL_ACC: state_next = ST_RED_ACC;
            ST_RED_ACC: begin
                if (rem_status.done) begin
                    // no bits left above this one: the last square is not needed
                    state_next = (expo_reg[W-1:1] == '0) ? ST_FINISH : ST_MUL_SQ;
                end
            end
            ST_MUL_SQ: state_next = ST_RED_SQ;
            ST_RED_SQ: begin
                if (rem_status.done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= (take_in && modulus != '0 && sel_expo != '0) ||
                         state_reg == ST_MUL_ACC || state_reg == ST_MUL_SQ;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (take_in) begin
                    kind_reg <= s_data.kind;
                    expo_reg <= sel_expo;
                    prod_reg <= (2 * W)'(sel_base);
                    acc_reg  <= (modulus == W'(1)) ? '0 : W'(1);
                    bad_reg  <= (modulus == '0);
                    res_reg  <= (modulus == '0) ? '0 : W'(1);
                end
            end
            ST_BASE_RED: begin
                if (rem_status.done) begin
                    sq_reg <= rem_value;
                end
            end
            ST_MUL_ACC: prod_reg <= prod_next;
            ST_RED_ACC: begin
                if (rem_status.done) begin
                    acc_reg <= rem_value;
                    res_reg <= rem_value;
                end
            end
            ST_MUL_SQ: prod_reg <= prod_next;
            ST_RED_SQ: begin
                if (rem_status.done) begin
                    sq_reg   <= rem_value;
                    expo_reg <= {1'b0, expo_reg[W-1:1]};
                end
            end
            default: ;
        endcase
        if (load_out) begin
            out_reg.bad_modulus <= bad_reg;
            if (kind_reg == mexp_pkg::KIND_DECRYPT) begin
                out_reg.power_result <=
                    mexp_pkg::FIELD_BITS'(res_reg[mexp_pkg::MSG_BITS-1:0]);
            end else begin
                out_reg.power_result <= mexp_pkg::FIELD_BITS'(res_reg);
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // remainder unit reports completion only while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_status.done |-> (state_reg == ST_BASE_RED || state_reg == ST_RED_ACC ||
                             state_reg == ST_RED_SQ))
        else $error("remainder done outside a reduction wait");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> !rem_status.busy)
        else $error("remainder unit restarted while busy");

    a_operands_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (acc_reg < modulus && sq_reg < modulus))
        else $error("operand not reduced below modulus");

    a_bad_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bad_modulus) |-> (m_data.power_result == '0))
        else $error("zero modulus result not cleared");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        take_in |=> !s_ready)
        else $error("input taken while an item is in progress");

endmodule
`default_nettype wire

// ===== dv/modular_exponentiation_unit_tb.sv =====
// self-checking testbench for the modular exponentiation unit
`timescale 1ns / 100ps
module modular_exponentiation_unit_tb;

    // unmapped register slot, writes there must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    mexp_pkg::mexp_in_t              s_data  = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    mexp_pkg::mexp_out_t             m_data;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [mexp_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [mexp_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [mexp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // key registers as the block should hold them
    logic [31:0] key_modulus = '0;
    logic [31:0] key_public  = '0;
    logic [31:0] key_private = '0;

    mexp_pkg::mexp_out_t expected_results[$];
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  mismatch_count = 0;
    int                  checked_count  = 0;
    int                  key_count      = 0;

    modular_exponentiation_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial forever #1 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("modular_exponentiation_unit_tb: FAIL");
        $finish;
    end

    function automatic mexp_pkg::mexp_out_t predict_power(input mexp_pkg::mexp_in_t item);
        logic [63:0]         modv;
        logic [63:0]         basev;
        logic [63:0]         acc;
        logic [63:0]         sq;
        logic [31:0]         expo;
        mexp_pkg::mexp_out_t res;
        res  = '0;
        modv = {32'd0, key_modulus};
        if (item.kind == mexp_pkg::KIND_DECRYPT) begin
            expo  = key_private;
            basev = {32'd0, item.base_value};
        end else begin
            expo  = key_public;
            basev = {56'd0, item.base_value[mexp_pkg::MSG_BITS-1:0]};
        end
        if (modv == 64'd0) begin
            res.bad_modulus = 1'b1;
            return res;
        end
        if (expo == 32'd0) begin
            // not reduced, so a modulus of one still gives one
            acc = 64'd1;
        end else begin
            acc = 64'd1 % modv;
            sq  = basev % modv;
            for (int i = 0; i < 32; i++) begin
                if (expo[i]) acc = (acc * sq) % modv;
                sq = (sq * sq) % modv;
            end
        end
        if (item.kind == mexp_pkg::KIND_DECRYPT) acc = acc & 64'hFF;
        res.power_result = acc[31:0];
        return res;
    endfunction

    // result side: random stalls, every transfer checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result power_result %h bad_modulus %b",
                         $time, m_data.power_result, m_data.bad_modulus);
                mismatch_count++;
            end else begin
                mexp_pkg::mexp_out_t want;
                want = expected_results.pop_front();
                checked_count++;
                if (m_data.power_result !== want.power_result) begin
                    $display("%0t: power_result expected %h actual %h",
                             $time, want.power_result, m_data.power_result);
                    mismatch_count++;
                end
                if (m_data.bad_modulus !== want.bad_modulus) begin
                    $display("%0t: bad_modulus expected %b actual %b",
                             $time, want.bad_modulus, m_data.bad_modulus);
                    mismatch_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input logic kind, input logic [31:0] base_value);
        mexp_pkg::mexp_in_t item;
        item.kind       = kind;
        item.base_value = base_value;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_power(item));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            mexp_pkg::REG_MODULUS:     key_modulus = value;
            mexp_pkg::REG_PUBLIC_EXP:  key_public  = value;
            mexp_pkg::REG_PRIVATE_EXP: key_private = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_key(input logic [31:0] modv, input logic [31:0] pub,
                           input logic [31:0] priv);
        wait_for_results();
        apb_write(mexp_pkg::REG_MODULUS, modv);
        apb_write(mexp_pkg::REG_PUBLIC_EXP, pub);
        apb_write(mexp_pkg::REG_PRIVATE_EXP, priv);
        key_count++;
    endtask

    // mostly short exponents so the run stays short, a few full width ones
    function automatic logic [31:0] pick_exponent();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return $urandom();
            2:       return 32'd65537;
            default: return $urandom_range(255, 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(19))
            0:       return 32'd0;
            1:       return 32'd1;
            2, 3, 4: return $urandom_range(255, 2);
            5:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_reset_defaults();
        // all registers zero after reset: flagged as a bad modulus
        send_item(mexp_pkg::KIND_ENCRYPT, 32'h0000_0000);
        send_item(mexp_pkg::KIND_DECRYPT, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed_corners();
        // zero exponent gives one even with a modulus of one
        set_key(32'd1, 32'd0, 32'd0);
        send_item(mexp_pkg::KIND_ENCRYPT, 32'h0000_00AB);
        send_item(mexp_pkg::KIND_DECRYPT, 32'h0000_1234);
        set_key(32'd1, 32'd5, 32'hFFFF_FFFF);
        send_item(mexp_pkg::KIND_ENCRYPT, 32'h0000_00FF);
        send_item(mexp_pkg::KIND_DECRYPT, 32'hFFFF_FFFF);
        // full width operands, upper message bits must be ignored
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(mexp_pkg::KIND_ENCRYPT, 32'h0000_00FF);
        send_item(mexp_pkg::KIND_ENCRYPT, 32'hFFFF_FF00);
        send_item(mexp_pkg::KIND_DECRYPT, 32'hFFFF_FFFF);
        send_item(mexp_pkg::KIND_DECRYPT, 32'hFFFF_FFFE);
        send_item(mexp_pkg::KIND_DECRYPT, 32'h8000_0001);
        // base at or above the modulus
        set_key(32'd97, 32'd3, 32'd7);
        send_item(mexp_pkg::KIND_ENCRYPT, 32'd200);
        send_item(mexp_pkg::KIND_ENCRYPT, 32'd97);
        send_item(mexp_pkg::KIND_DECRYPT, 32'hFFFF_FFFF);
        send_item(mexp_pkg::KIND_DECRYPT, 32'd96);
        wait_for_results();
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        send_item(mexp_pkg::KIND_ENCRYPT, 32'h0000_0005);
        send_item(mexp_pkg::KIND_DECRYPT, 32'h0000_0005);
        // zero modulus wins over nonzero exponents
        set_key(32'd0, 32'd65537, 32'd3);
        send_item(mexp_pkg::KIND_ENCRYPT, 32'h0000_007F);
        send_item(mexp_pkg::KIND_DECRYPT, 32'h8000_0000);
        set_key(32'hFFFF_FFFB, 32'd65537, 32'd2);
        send_item(mexp_pkg::KIND_ENCRYPT, 32'h0000_0002);
        send_item(mexp_pkg::KIND_DECRYPT, 32'hDEAD_BEEF);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 12 == 0) set_key(pick_modulus(), pick_exponent(), pick_exponent());
            send_item(1'($urandom_range(1)), $urandom());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_corners();
        test_random_traffic(66, 0, 0);
        test_random_traffic(66, 79, 0);
        test_random_traffic(66, 0, 79);
        test_random_traffic(66, 9, 9);
        wait_for_results();
        repeat (20) @(posedge aclk);
        $display("checked %0d results over %0d key settings", checked_count, key_count);
        $display("handshake phases: no gaps, sender gaps, receiver stalls, both");
        if (mismatch_count == 0) begin
            $display("modular_exponentiation_unit_tb: PASS");
        end else begin
            $display("modular_exponentiation_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
